[rtl/fphm_pkg.sv]
// Package for the flow pulse heat meter: widths, register indexes, item kinds,
// the constant multipliers of the flow and power arithmetic, and the lane result type.
// No dependencies.
`default_nettype none
package fphm_pkg;

  localparam int SENSORS     = 2;
  localparam int CNT_W       = 8;
  localparam int DT_W        = 12;
  localparam int DTC_W       = 11;
  localparam int FLOW_W      = 8;
  localparam int POW_W       = 16;
  localparam int BASE_W      = 24;
  localparam int PROD_W      = 35;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  localparam logic FUNC_PULSE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_PRIMARY_MIN   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SECONDARY_MIN = 2'd1;

  // Flow is p*50/33, done as p*(50*ceil(2^20/33)) >> 20.
  localparam logic [20:0] FLOW_MUL = 21'd1588800;
  // Base is p*411600/11 = p*37418 + floor(2p/11); the fraction uses ceil(2^12/11).
  localparam logic [15:0] BASE_MUL      = 16'd37418;
  localparam logic [9:0]  BASE_FRAC_MUL = 10'd746;
  // Power is base*d/57600; 57600 = 256*225, and /225 is *ceil(2^32/225) >> 32.
  localparam logic [PROD_W-1:0] POW_SAT_LIM = 35'd3774873600;
  localparam logic [24:0]       POW_DIV_MUL = 25'd19088744;

  typedef struct packed {
    logic [FLOW_W-1:0] flow;
    logic [POW_W-1:0]  power;
  } lane_res_t;

endpackage
`default_nettype wire

[rtl/flow_pulse_heat_meter_unit.sv]
// Top level of the flow pulse heat meter: pulse counters, configuration
// registers, two sensor lanes and the merging stage. Depends on fphm_pkg,
// fphm_lane and fphm_merge.
//
// Usage: the input stream carries pulse and tick requests. A pulse request
// (in_tuser[0] low) adds one to the count of the sensor in in_tuser[1],
// holding at 255, and is taken without a result. A tick request hands both
// counts and temperature differences to the two lanes, clears the counts and
// gives exactly one result request on the output stream.
// A tick passes through four lane stages, a pending stage and the output
// register before out_tvalid rises. in_tready stays low from a tick until
// its result is loaded into the output register, so a new tick is taken only
// after the last result is loaded; pulses are taken every cycle otherwise.
// A stalled receiver holds the result in the output register, and a finished
// tick waits in the lanes until it can be loaded. Synchronous reset clears
// the counts, the thresholds and all valid flags. Thresholds are written
// through cfg_we, cfg_addr and cfg_wdata; the user must write them only
// while the block is idle, which the block itself does not enforce.
`default_nettype none
module flow_pulse_heat_meter_unit import fphm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Low to high: delta_temp_primary[11:0], delta_temp_secondary[23:12].
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Low to high: func[0], sensor[1].
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // Low to high: flow_primary[7:0], flow_secondary[15:8], power_primary[31:16],
  // power_secondary[47:32], flow_nominal[48], zero fill[55:49].
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic [CNT_W-1:0]      cnt_r   [SENSORS];
  logic [CNT_W-1:0]      cnt_nxt [SENSORS];
  logic                  busy_r;
  logic                  busy_nxt;
  logic [CFG_DATA_W-1:0] min_primary_r;
  logic [CFG_DATA_W-1:0] min_secondary_r;
  logic                  accept;
  logic                  tick;
  logic                  pulse;
  logic                  lane_done [SENSORS];
  lane_res_t             lane_res  [SENSORS];
  logic                  loaded;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign tick      = accept && (in_tuser[0] == FUNC_TICK);
  assign pulse     = accept && (in_tuser[0] == FUNC_PULSE);

  always_comb begin
    for (int i = 0; i < SENSORS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (tick) begin
        cnt_nxt[i] = '0;
      end else if (pulse && (in_tuser[1] == 1'(i)) && (cnt_r[i] != CNT_MAX)) begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end
    end
    busy_nxt = busy_r;
    if (tick) begin
      busy_nxt = 1'b1;
    end else if (loaded) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSORS; i++) begin
        cnt_r[i] <= '0;
      end
      busy_r          <= 1'b0;
      min_primary_r   <= '0;
      min_secondary_r <= '0;
    end else begin
      for (int i = 0; i < SENSORS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      busy_r <= busy_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_PRIMARY_MIN:   min_primary_r   <= cfg_wdata;
          CFG_SECONDARY_MIN: min_secondary_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  for (genvar g = 0; g < SENSORS; g++) begin : g_lane
    fphm_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (tick),
      .cnt   (cnt_r[g]),
      .dt    (in_tdata[g*DT_W +: DT_W]),
      .done  (lane_done[g]),
      .res   (lane_res[g])
    );
  end

  fphm_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .lane_done     (lane_done[0]),
    .res           (lane_res),
    .min_primary   (min_primary_r),
    .min_secondary (min_secondary_r),
    .loaded        (loaded),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] == lane_done[1])
    else $error("sensor lanes finished out of step");

  a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> busy_r)
    else $error("lane finished without a tick in flight");

  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> (cnt_r[0] == '0) && (cnt_r[1] == '0))
    else $error("pulse counts not cleared by tick");

  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(busy_r))
    else $error("result appeared without a tick");

endmodule
`default_nettype wire

[rtl/fphm_lane.sv]
// One sensor lane: a four-stage pipeline turning a pulse count and a temperature
// difference into a saturated flow and power. Depends on fphm_pkg.
`default_nettype none
module fphm_lane import fphm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [CNT_W-1:0]        cnt,
  input  wire logic signed [DT_W-1:0]  dt,
  output logic                         done,
  output lane_res_t                    res
);

  logic [3:0]        vld_r;
  logic [3:0]        vld_nxt;
  logic [CNT_W-1:0]  p_r;
  logic [DTC_W-1:0]  d_r;
  logic [DTC_W-1:0]  d1_r;
  logic [BASE_W-1:0] base_r;
  logic [BASE_W-1:0] base_nxt;
  logic [FLOW_W-1:0] flow_r;
  logic [FLOW_W-1:0] flow_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [POW_W-1:0]  power_r;
  logic [POW_W-1:0]  power_nxt;
  logic [28:0]       flow_prod;
  logic [BASE_W-1:0] base_int;
  logic [17:0]       frac_prod;
  logic [48:0]       pow_prod;

  assign vld_nxt = {vld_r[2:0], start};

  always_comb begin
    flow_prod = {21'd0, p_r} * {8'd0, FLOW_MUL};
    flow_nxt  = flow_prod[28] ? {FLOW_W{1'b1}} : flow_prod[27:20];
    base_int  = {16'd0, p_r} * {8'd0, BASE_MUL};
    frac_prod = {10'd0, p_r} * {8'd0, BASE_FRAC_MUL};
    base_nxt  = base_int + {18'd0, frac_prod[17:12]};
    prod_nxt  = {11'd0, base_r} * {24'd0, d1_r};
    pow_prod  = {25'd0, prod_r[31:8]} * {24'd0, POW_DIV_MUL};
    power_nxt = (prod_r >= POW_SAT_LIM) ? {POW_W{1'b1}} : pow_prod[47:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_r <= cnt;
      d_r <= dt[DT_W-1] ? '0 : dt[DTC_W-1:0];
    end
    if (vld_r[0]) begin
      base_r <= base_nxt;
      flow_r <= flow_nxt;
      d1_r   <= d_r;
    end
    if (vld_r[1]) begin
      prod_r <= prod_nxt;
    end
    if (vld_r[2]) begin
      power_r <= power_nxt;
    end
  end

  assign done      = vld_r[3];
  assign res.flow  = flow_r;
  assign res.power = power_r;

endmodule
`default_nettype wire

[rtl/fphm_merge.sv]
// Merging stage: combines the lane results, flags nominal flow and holds the
// result request in the output register. Depends on fphm_pkg.
`default_nettype none
module fphm_merge import fphm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    lane_done,
  input  wire lane_res_t               res [SENSORS],
  input  wire logic [CFG_DATA_W-1:0]   min_primary,
  input  wire logic [CFG_DATA_W-1:0]   min_secondary,
  output logic                         loaded,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata
);

  logic                   pend_r;
  logic                   pend_nxt;
  logic                   valid_r;
  logic                   valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;
  logic                   nominal;

  assign nominal = (res[0].flow > min_primary) && (res[1].flow > min_secondary);
  assign loaded  = pend_r && (!valid_r || out_tready);

  always_comb begin
    pend_nxt  = pend_r;
    valid_nxt = valid_r;
    if (valid_r && out_tready) begin
      valid_nxt = 1'b0;
    end
    if (loaded) begin
      pend_nxt  = 1'b0;
      valid_nxt = 1'b1;
    end
    if (lane_done) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (loaded) begin
      data_r <= {7'd0, nominal, res[1].power, res[0].power, res[1].flow, res[0].flow};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule
`default_nettype wire
